@@ hw/rtl/tce_pkg.sv @@
`timescale 1ns / 1ps

package tce_pkg;

  // Field widths of the command and response items.
  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_PUT     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RECOLOR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd3;

  // Control characters and the reset attribute.
  localparam logic [CHAR_W-1:0]  CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0]  CODE_NEWLINE   = 8'd10;
  localparam logic [COLOR_W-1:0] RESET_COLOR    = 8'h07;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] color;
    logic [INDEX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]   cursor_pos;
    logic [CHAR_W-1:0]  read_char;
    logic [COLOR_W-1:0] read_attr;
  } result_t;

endpackage

@@ hw/rtl/tce_if.sv @@
`timescale 1ns / 1ps

// Command channel: one console operation per item.
interface tce_cmd_if;
  import tce_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] color;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, func, char_code, color, cell_index, input ready);
  modport sink   (input valid, func, char_code, color, cell_index, output ready);
endinterface

// Response channel: one item per command.
interface tce_rsp_if;
  import tce_pkg::*;

  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   cursor_pos;
  logic [CHAR_W-1:0]  read_char;
  logic [COLOR_W-1:0] read_attr;

  modport source (output valid, cursor_pos, read_char, read_attr, input ready);
  modport sink   (input valid, cursor_pos, read_char, read_attr, output ready);
endinterface

@@ hw/rtl/tce_cell_ram.sv @@
`timescale 1ns / 1ps

module tce_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [tce_pkg::CELL_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [tce_pkg::CELL_W-1:0] rdata
);
  import tce_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/tce_seq.sv @@
`timescale 1ns / 1ps

module tce_seq #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int SCROLL_ROW = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tce_pkg::COLOR_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tce_pkg::item_t              in_item,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tce_pkg::result_t            res
);
  import tce_pkg::*;

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int AW        = $clog2(CELLS);
  localparam int PTRW      = $clog2(CELLS + 1);
  localparam int CW        = $clog2(COLUMNS + 1);
  localparam int RW        = $clog2(SCROLL_ROW + 1);
  localparam int LW        = $clog2((SCROLL_ROW + 1) * COLUMNS + 1);
  localparam int IW        = (PTRW > INDEX_W) ? PTRW : INDEX_W;
  // Last row that moves up during a scroll, and the end of the copied range.
  localparam int TOP_ROW   = (SCROLL_ROW < ROWS - 1) ? SCROLL_ROW : ROWS - 1;
  localparam int COPY_END  = (TOP_ROW + 1) * COLUMNS;
  // The vacated row is cleared only when it lies inside the store.
  localparam bit CLR_ROW   = (SCROLL_ROW < ROWS);
  localparam int CLR_START = CLR_ROW ? SCROLL_ROW * COLUMNS : 0;
  localparam int CLR_END   = CLR_ROW ? CLR_START + COLUMNS : 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_BS_RD, S_BS_WR, S_COPY, S_CLR_ROW, S_WRAP,
    S_PUT, S_FILL, S_RECOLOR, S_READ, S_DONE
  } state_t;

  state_t              state;
  item_t               item;
  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic [COLOR_W-1:0]  default_color;
  logic [PTRW-1:0]     ptr;
  logic                pend;
  logic [AW-1:0]       pend_addr;
  logic [CHAR_W-1:0]   rd_char;
  logic [COLOR_W-1:0]  rd_attr;

  logic [LW-1:0]       cur_lin;
  logic [AW-1:0]       cur_addr;
  logic                cur_in_range;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  tce_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Linear cursor position and the cell it points at.
  always_comb begin
    cur_lin      = LW'(row) * LW'(COLUMNS) + LW'(col);
    cur_addr     = AW'(cur_lin);
    cur_in_range = (int'(row) < ROWS) && (int'(col) < COLUMNS);
  end

  // Memory port control for each step of the sequencer.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = AW'(ptr);
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr);
      end
      S_IDLE: begin
        ram_re    = in_valid && (in_item.func == FUNC_READ);
        ram_raddr = AW'(in_item.cell_index);
      end
      S_BS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_addr;
      end
      S_BS_WR: begin
        ram_we    = cur_in_range;
        ram_waddr = cur_addr;
        ram_wdata = {ram_rdata[CELL_W-1:CHAR_W], {CHAR_W{1'b0}}};
      end
      S_COPY: begin
        ram_re    = (ptr != PTRW'(COPY_END));
        ram_we    = pend;
        ram_wdata = ram_rdata;
      end
      S_CLR_ROW: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr);
      end
      S_PUT: begin
        ram_we    = (item.char_code != CODE_NEWLINE) && cur_in_range;
        ram_waddr = cur_addr;
        ram_wdata = {item.color, item.char_code};
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr);
        ram_wdata = {default_color, {CHAR_W{1'b0}}};
      end
      S_RECOLOR: begin
        ram_re    = (ptr != PTRW'(CELLS));
        ram_we    = pend;
        ram_wdata = {item.color[7:4], ram_rdata[11:8], ram_rdata[CHAR_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  // Sequencer: one item at a time, sweeps over the store one cell a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      ptr           <= '0;
      pend          <= 1'b0;
      col           <= '0;
      row           <= '0;
      default_color <= RESET_COLOR;
    end else begin
      if (cfg_wr_en) begin
        default_color <= cfg_wr_data;
      end
      case (state)
        S_INIT: begin
          if (ptr == PTRW'(CELLS - 1)) begin
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item    <= in_item;
            rd_char <= '0;
            rd_attr <= '0;
            ptr     <= '0;
            pend    <= 1'b0;
            case (in_item.func)
              FUNC_PUT: begin
                if (in_item.char_code == CODE_BACKSPACE) begin
                  if (col != '0) begin
                    col   <= col - 1'b1;
                    state <= S_BS_RD;
                  end else if (row != '0) begin
                    row   <= row - 1'b1;
                    col   <= CW'(COLUMNS - 1);
                    state <= S_BS_RD;
                  end else begin
                    state <= S_DONE;
                  end
                end else if (int'(row) >= SCROLL_ROW) begin
                  ptr   <= PTRW'(COLUMNS);
                  state <= S_COPY;
                end else begin
                  state <= S_WRAP;
                end
              end
              FUNC_CLEAR: begin
                col   <= '0;
                row   <= '0;
                state <= S_FILL;
              end
              FUNC_RECOLOR: begin
                default_color <= in_item.color;
                state         <= S_RECOLOR;
              end
              default: begin
                if (IW'(in_item.cell_index) < IW'(CELLS)) begin
                  state <= S_READ;
                end else begin
                  state <= S_DONE;
                end
              end
            endcase
          end
        end
        S_BS_RD: begin
          state <= S_BS_WR;
        end
        S_BS_WR: begin
          state <= S_DONE;
        end
        // Read one row below, write it one row up on the following cycle.
        S_COPY: begin
          if (ptr != PTRW'(COPY_END)) begin
            ptr       <= ptr + 1'b1;
            pend      <= 1'b1;
            pend_addr <= AW'(ptr - PTRW'(COLUMNS));
          end else begin
            pend <= 1'b0;
            if (CLR_ROW) begin
              ptr   <= PTRW'(CLR_START);
              state <= S_CLR_ROW;
            end else begin
              row   <= row - 1'b1;
              state <= S_WRAP;
            end
          end
        end
        S_CLR_ROW: begin
          if (ptr == PTRW'(CLR_END - 1)) begin
            row   <= row - 1'b1;
            state <= S_WRAP;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_WRAP: begin
          if ((item.char_code == CODE_NEWLINE) || (int'(col) >= COLUMNS)) begin
            row <= row + 1'b1;
            col <= '0;
          end
          state <= (item.char_code == CODE_NEWLINE) ? S_DONE : S_PUT;
        end
        S_PUT: begin
          col   <= col + 1'b1;
          state <= S_DONE;
        end
        S_FILL: begin
          if (ptr == PTRW'(CELLS - 1)) begin
            state <= S_DONE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        // Read each cell and write it back with the new background on the following cycle.
        S_RECOLOR: begin
          if (ptr != PTRW'(CELLS)) begin
            ptr       <= ptr + 1'b1;
            pend      <= 1'b1;
            pend_addr <= AW'(ptr);
          end else begin
            pend  <= 1'b0;
            state <= S_DONE;
          end
        end
        S_READ: begin
          rd_char <= ram_rdata[CHAR_W-1:0];
          rd_attr <= ram_rdata[CELL_W-1:CHAR_W];
          state   <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Handshake toward the channels.
  assign in_ready       = (state == S_IDLE);
  assign res_valid      = (state == S_DONE);
  assign res.cursor_pos = POS_W'(cur_lin);
  assign res.read_char  = rd_char;
  assign res.read_attr  = rd_attr;

endmodule

@@ hw/rtl/text_console_cell_engine.sv @@
`timescale 1ns / 1ps

// Text console engine over a ROWS x COLUMNS store of character/attribute cells.
// Commands arrive on the cmd channel (valid/ready); each command produces
// exactly one item on the rsp channel carrying the linear cursor position and,
// for a cell read, the character and attribute of that cell.
// The default clear color is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, since the block itself does not enforce this.
// Full clear, recolor and scroll sweep over the cell memory, one cell per cycle.
// Each result passes through the rsp output register.
// One command is worked on at a time; the next is taken while the previous
// result still waits in the output register.
// After reset the block clears all ROWS*COLUMNS cells, one per cycle, and
// accepts no command until that pass ends.
// When the receiver stalls, the output register holds its item; the sequencer
// still finishes the next command, then waits with that result and accepts
// nothing more until the register drains.
module text_console_cell_engine #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int SCROLL_ROW = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tce_pkg::COLOR_W-1:0] cfg_wr_data,
  tce_cmd_if.sink                     cmd,
  tce_rsp_if.source                   rsp
);
  import tce_pkg::*;

  item_t   cmd_item;
  result_t res;
  result_t out_data;
  logic    res_valid;
  logic    res_ready;
  logic    out_valid;

  assign cmd_item.func       = cmd.func;
  assign cmd_item.char_code  = cmd.char_code;
  assign cmd_item.color      = cmd.color;
  assign cmd_item.cell_index = cmd.cell_index;

  tce_seq #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .SCROLL_ROW (SCROLL_ROW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (cmd.valid),
    .in_ready    (cmd.ready),
    .in_item     (cmd_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register between the sequencer and the response channel.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cursor_pos = out_data.cursor_pos;
  assign rsp.read_char  = out_data.read_char;
  assign rsp.read_attr  = out_data.read_attr;

  // Only one command is in flight: the sequencer leaves idle once it takes one.
  assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command accepted twice in a row");

  // An idle sequencer holds no finished result.
  assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !res_valid)
    else $error("sequencer idle with a pending result");

  // A result that is handed over shows up on the response channel next cycle.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> rsp.valid)
    else $error("result lost at the output register");

  // A result that is not taken stays pending in the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while the output register was full");

endmodule

@@ verif/text_console_cell_engine_tb.sv @@
`timescale 1ns / 1ps

module text_console_cell_engine_tb;
  import tce_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int SCROLL_ROW = 24;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int INDEX_SPAN = 1 << INDEX_W;
  localparam int ITEM_GOAL  = 300;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [COLOR_W-1:0] cfg_wr_data;

  tce_cmd_if cmd ();
  tce_rsp_if rsp ();

  text_console_cell_engine #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .SCROLL_ROW(SCROLL_ROW)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .rsp        (rsp)
  );

  // Shadow copy of the screen, the cursor and the clear color.
  logic [CELL_W-1:0]  screen [CELL_COUNT];
  int unsigned        cur_col;
  int unsigned        cur_row;
  logic [COLOR_W-1:0] clear_color;

  result_t pending_results [$];
  int      error_count;
  int      result_count;
  int      scroll_count;
  int      items_sent;
  int      op_count [4];
  bit      sender_relaxed;
  bit      receiver_relaxed;
  int      rsp_stall;

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Cells outside the screen are silently dropped.
  function automatic void write_screen(int unsigned row, int unsigned col,
                                       logic [CELL_W-1:0] value);
    if (row < ROWS && col < COLUMNS) begin
      screen[row * COLUMNS + col] = value;
    end
  endfunction

  // Applies one command to the shadow console and returns the response it must produce.
  function automatic result_t predict_console(item_t it);
    result_t     res;
    int unsigned r;
    int unsigned c;
    int unsigned idx;
    res = '0;
    case (it.func)
      FUNC_PUT: begin
        if (it.char_code == CODE_BACKSPACE) begin
          // Step back one cell and blank its character; the origin is a dead stop.
          if (cur_col != 0 || cur_row != 0) begin
            if (cur_col != 0) begin
              cur_col--;
            end else begin
              cur_row--;
              cur_col = COLUMNS - 1;
            end
            if (cur_row < ROWS && cur_col < COLUMNS) begin
              idx = cur_row * COLUMNS + cur_col;
              screen[idx][CHAR_W-1:0] = '0;
            end
          end
        end else begin
          // At the bottom row the screen moves up one line first.
          if (cur_row >= SCROLL_ROW) begin
            for (r = 1; r <= cur_row && r < ROWS; r++) begin
              for (c = 0; c < COLUMNS; c++) begin
                screen[(r - 1) * COLUMNS + c] = screen[r * COLUMNS + c];
              end
            end
            for (c = 0; c < COLUMNS; c++) begin
              write_screen(cur_row, c, '0);
            end
            if (cur_row > 0) begin
              cur_row--;
            end
            scroll_count++;
          end
          if (it.char_code == CODE_NEWLINE || cur_col >= COLUMNS) begin
            cur_row++;
            cur_col = 0;
          end
          if (it.char_code != CODE_NEWLINE) begin
            write_screen(cur_row, cur_col, {it.color, it.char_code});
            cur_col++;
          end
        end
      end
      FUNC_CLEAR: begin
        cur_col = 0;
        cur_row = 0;
        for (idx = 0; idx < CELL_COUNT; idx++) begin
          screen[idx] = {clear_color, {CHAR_W{1'b0}}};
        end
      end
      FUNC_RECOLOR: begin
        // New background everywhere; the foreground nibble stays.
        clear_color = it.color;
        for (idx = 0; idx < CELL_COUNT; idx++) begin
          screen[idx][CELL_W-1 -: 4] = it.color[COLOR_W-1 -: 4];
        end
      end
      default: begin
        if (it.cell_index < CELL_COUNT) begin
          res.read_char = screen[it.cell_index][CHAR_W-1:0];
          res.read_attr = screen[it.cell_index][CELL_W-1:CHAR_W];
        end
      end
    endcase
    res.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  // Sends one command item after a random gap and records its expected response.
  task automatic send_command(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                              logic [COLOR_W-1:0] color, logic [INDEX_W-1:0] index);
    item_t it;
    int    gap;
    it.func       = func;
    it.char_code  = ch;
    it.color      = color;
    it.cell_index = index;
    gap = sender_relaxed ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.func       <= it.func;
    cmd.char_code  <= it.char_code;
    cmd.color      <= it.color;
    cmd.cell_index <= it.cell_index;
    @(posedge clk);
    while (cmd.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(predict_console(it));
    op_count[it.func]++;
    items_sent++;
  endtask

  // Lets every outstanding response come back so the block is idle.
  task automatic drain_results();
    cmd.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_clear_color(logic [COLOR_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    clear_color = value;
  endtask

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Response side: random back-pressure and an in-order compare of every item.
  always @(posedge clk) begin : rsp_monitor
    result_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response, cursor_pos %0d read_char %0d read_attr %0d",
                 $time, rsp.cursor_pos, rsp.read_char, rsp.read_attr);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("cursor_pos", want.cursor_pos, rsp.cursor_pos);
        compare_field("read_char", want.read_char, rsp.read_char);
        compare_field("read_attr", want.read_attr, rsp.read_attr);
      end
      result_count++;
      rsp_stall = receiver_relaxed ? 0 : $urandom_range(0, 13);
    end else if (rsp_stall > 0) begin
      rsp_stall--;
    end
    rsp.ready <= (rsp_stall == 0);
  end

  // The screen after the power-up clearing pass, including reads past the end.
  task automatic test_reset_contents();
    send_command(FUNC_READ, $urandom, $urandom, 0);
    send_command(FUNC_READ, $urandom, $urandom, CELL_COUNT - 1);
    send_command(FUNC_READ, $urandom, $urandom, INDEX_SPAN - 1);
    send_command(FUNC_READ, $urandom, $urandom, CELL_COUNT);
  endtask

  // Full clear with the reset color, then with written colors at both extremes and one between.
  task automatic test_clear_color();
    send_command(FUNC_CLEAR, $urandom, $urandom, $urandom);
    send_command(FUNC_READ, $urandom, $urandom, 1234);
    set_clear_color(8'hFF);
    send_command(FUNC_CLEAR, $urandom, $urandom, $urandom);
    send_command(FUNC_READ, $urandom, $urandom, CELL_COUNT - 1);
    set_clear_color(8'h00);
    send_command(FUNC_CLEAR, $urandom, $urandom, $urandom);
    set_clear_color(8'h5A);
    send_command(FUNC_CLEAR, $urandom, $urandom, $urandom);
  endtask

  // Characters and colors at their extremes.
  task automatic test_put_extremes();
    send_command(FUNC_PUT, 8'hFF, 8'hFF, $urandom);
    send_command(FUNC_PUT, 8'h00, 8'h00, $urandom);
    send_command(FUNC_READ, $urandom, $urandom, 1);
  endtask

  // Backspace inside a row, at the origin, and back across a row boundary.
  task automatic test_backspace();
    send_command(FUNC_PUT, CODE_BACKSPACE, $urandom, $urandom);
    send_command(FUNC_PUT, CODE_BACKSPACE, $urandom, $urandom);
    send_command(FUNC_PUT, CODE_BACKSPACE, $urandom, $urandom);
    send_command(FUNC_PUT, 8'h41, 8'h1E, $urandom);
    send_command(FUNC_PUT, CODE_NEWLINE, $urandom, $urandom);
    send_command(FUNC_PUT, CODE_BACKSPACE, $urandom, $urandom);
    send_command(FUNC_READ, $urandom, $urandom, 0);
    send_command(FUNC_READ, $urandom, $urandom, COLUMNS - 1);
  endtask

  // Recolor keeps foregrounds and becomes the next clear color.
  task automatic test_recolor();
    send_command(FUNC_RECOLOR, $urandom, 8'hC3, $urandom);
    send_command(FUNC_READ, $urandom, $urandom, 0);
    send_command(FUNC_RECOLOR, $urandom, 8'h0F, $urandom);
    send_command(FUNC_CLEAR, $urandom, $urandom, $urandom);
    send_command(FUNC_READ, $urandom, $urandom, CELL_COUNT - 1);
  endtask

  // A full row, a backspace from the end of it, and the wrap into the next row.
  task automatic test_row_wrap();
    int c;
    sender_relaxed = 1'b1;
    send_command(FUNC_CLEAR, $urandom, $urandom, $urandom);
    for (c = 0; c < COLUMNS; c++) begin
      send_command(FUNC_PUT, $urandom_range(32, 126), $urandom_range(0, 255), $urandom);
    end
    send_command(FUNC_PUT, CODE_BACKSPACE, $urandom, $urandom);
    send_command(FUNC_PUT, $urandom_range(32, 126), $urandom_range(0, 255), $urandom);
    send_command(FUNC_PUT, $urandom_range(32, 126), $urandom_range(0, 255), $urandom);
    send_command(FUNC_READ, $urandom, $urandom, COLUMNS - 1);
    send_command(FUNC_READ, $urandom, $urandom, COLUMNS);
    sender_relaxed = 1'b0;
  endtask

  // Short lines down to the bottom row and past it, so that the screen scrolls.
  task automatic test_scroll();
    int n;
    receiver_relaxed = 1'b1;
    for (n = 0; n < 30; n++) begin
      send_command(FUNC_PUT, $urandom_range(32, 126), $urandom_range(0, 255), $urandom);
      send_command(FUNC_PUT, CODE_NEWLINE, $urandom, $urandom);
    end
    send_command(FUNC_PUT, CODE_BACKSPACE, $urandom, $urandom);
    send_command(FUNC_READ, $urandom, $urandom, (SCROLL_ROW - 1) * COLUMNS);
    send_command(FUNC_READ, $urandom, $urandom, SCROLL_ROW * COLUMNS);
    send_command(FUNC_READ, $urandom, $urandom, $urandom_range(0, COLUMNS - 1));
    receiver_relaxed = 1'b0;
  endtask

  // Mostly well-formed editing sequences with random content, plus some noise.
  task automatic test_random_traffic();
    int          pick;
    int          len;
    int unsigned here;
    int unsigned back;
    int unsigned idx;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 99) < 15) sender_relaxed = !sender_relaxed;
      if ($urandom_range(0, 99) < 15) receiver_relaxed = !receiver_relaxed;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // A line of text, now and then long enough to wrap.
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(76, 84) : $urandom_range(0, 3);
        repeat (len) begin
          send_command(FUNC_PUT, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
        end
        if ($urandom_range(0, 99) < 85) begin
          send_command(FUNC_PUT, CODE_NEWLINE, $urandom, $urandom);
        end
      end else if (pick < 52) begin
        repeat ($urandom_range(3, 10)) send_command(FUNC_PUT, CODE_NEWLINE, $urandom, $urandom);
      end else if (pick < 64) begin
        repeat ($urandom_range(1, 6)) send_command(FUNC_PUT, CODE_BACKSPACE, $urandom, $urandom);
      end else if (pick < 84) begin
        // Reads near the cursor, anywhere on screen, or past its end.
        repeat ($urandom_range(1, 3)) begin
          len = $urandom_range(0, 99);
          if (len < 40) begin
            here = cur_row * COLUMNS + cur_col;
            back = $urandom_range(0, 3);
            idx  = (here > back) ? here - back : 0;
          end else if (len < 85) begin
            idx = $urandom_range(0, CELL_COUNT - 1);
          end else begin
            idx = $urandom_range(CELL_COUNT, INDEX_SPAN - 1);
          end
          send_command(FUNC_READ, $urandom, $urandom, idx);
        end
      end else if (pick < 90) begin
        send_command(FUNC_RECOLOR, $urandom, $urandom_range(0, 255), $urandom);
      end else if (pick < 94) begin
        send_command(FUNC_CLEAR, $urandom, $urandom, $urandom);
      end else if (pick < 97) begin
        send_command($urandom_range(0, 3), $urandom, $urandom, $urandom);
      end else begin
        len = $urandom_range(0, 2);
        set_clear_color((len == 0) ? 8'h00 : (len == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Reset, the directed checks, the random traffic and the verdict.
  initial begin : main
    int i;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    cmd.valid        = 1'b0;
    cmd.func         = FUNC_PUT;
    cmd.char_code    = '0;
    cmd.color        = '0;
    cmd.cell_index   = '0;
    rsp.ready        = 1'b0;
    rsp_stall        = 0;
    sender_relaxed   = 1'b0;
    receiver_relaxed = 1'b0;
    error_count      = 0;
    result_count     = 0;
    scroll_count     = 0;
    items_sent       = 0;
    for (i = 0; i < 4; i++) op_count[i] = 0;
    for (i = 0; i < CELL_COUNT; i++) screen[i] = '0;
    cur_col     = 0;
    cur_row     = 0;
    clear_color = RESET_COLOR;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_contents();
    test_clear_color();
    test_put_extremes();
    test_backspace();
    test_recolor();
    test_row_wrap();
    test_scroll();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d commands: %0d puts, %0d clears, %0d recolors, %0d reads.",
             items_sent, op_count[FUNC_PUT], op_count[FUNC_CLEAR],
             op_count[FUNC_RECOLOR], op_count[FUNC_READ]);
    $display("%0d screen scrolls; %0d responses checked with %0d mismatches.",
             scroll_count, result_count, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
